/* src/stt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types, constants and helpers of the source text tokenizer
// Character classes, token class codes, scanner modes and the word types
// that travel between the scanner, the result queue and the register block.
// ----------------------------------------------------------------------------
package stt_pkg;

	// field widths
	localparam int CHAR_W        = 8;
	localparam int CLASS_W       = 6;
	localparam int LINE_FIELD_W  = 20;
	localparam int LINE_BITS_DEF = 20;

	// register port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-3:0] REG_FIRST_LINE = '0;
	localparam logic [LINE_FIELD_W-1:0] FIRST_LINE_RESET = 20'd1;

	// result queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	// keyword tracking
	localparam logic [2:0] KW_LEN  = 3'd6;
	localparam logic [2:0] KW_DEAD = 3'd7;

	// special characters
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ESC_N  = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_ESC_T  = 8'h74;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_OPER,
		MODE_STR,
		MODE_ESC
	} mode_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_UNKNOWN, CLS_INT, CLS_FLOAT, CLS_STRING,
		CLS_PLUS, CLS_INC, CLS_PLUS_EQ,
		CLS_MINUS, CLS_DEC, CLS_MINUS_EQ, CLS_ARROW,
		CLS_STAR, CLS_STAR_EQ, CLS_SLASH, CLS_SLASH_EQ,
		CLS_PCT, CLS_PCT_EQ, CLS_AMP, CLS_AMP_EQ,
		CLS_BAR, CLS_BAR_EQ, CLS_CARET, CLS_COLON, CLS_SCOPE,
		CLS_LBRACE, CLS_RBRACE, CLS_LPAREN, CLS_RPAREN,
		CLS_LBRACK, CLS_RBRACK, CLS_DOT, CLS_SEMI, CLS_COMMA,
		CLS_STRUCT, CLS_IDENT
	} token_class_t;

	typedef struct packed {
		logic [CHAR_W-1:0]       out_char;
		logic                    char_valid;
		logic                    last_of_token;
		logic [CLASS_W-1:0]      token_class;
		logic [LINE_FIELD_W-1:0] line_number;
	} result_t;

	// up to two result words per source word
	typedef struct packed {
		logic    en0;
		logic    en1;
		result_t item0;
		result_t item1;
	} push_t;

	typedef struct packed {
		logic                    load;
		logic [LINE_FIELD_W-1:0] load_value;
		logic [LINE_FIELD_W-1:0] first_line;
	} cfg_t;

	function automatic logic is_digit(logic [CHAR_W-1:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(logic [CHAR_W-1:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic needs_lookahead(logic [CHAR_W-1:0] c);
		return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
			(c == "%") || (c == "&") || (c == "|") || (c == ":");
	endfunction

	function automatic token_class_t single_class(logic [CHAR_W-1:0] c);
		token_class_t cls;
		case (c)
			"+": cls = CLS_PLUS;
			"-": cls = CLS_MINUS;
			"*": cls = CLS_STAR;
			"/": cls = CLS_SLASH;
			"%": cls = CLS_PCT;
			"&": cls = CLS_AMP;
			"|": cls = CLS_BAR;
			"^": cls = CLS_CARET;
			":": cls = CLS_COLON;
			"{": cls = CLS_LBRACE;
			"}": cls = CLS_RBRACE;
			"(": cls = CLS_LPAREN;
			")": cls = CLS_RPAREN;
			"[": cls = CLS_LBRACK;
			"]": cls = CLS_RBRACK;
			".": cls = CLS_DOT;
			";": cls = CLS_SEMI;
			",": cls = CLS_COMMA;
			default: cls = CLS_UNKNOWN;
		endcase
		return cls;
	endfunction

	// two-character operator class, unknown when the pair forms none
	function automatic token_class_t pair_class(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
		token_class_t cls;
		cls = CLS_UNKNOWN;
		case (a)
			"+": begin
				if (b == "+") cls = CLS_INC;
				else if (b == "=") cls = CLS_PLUS_EQ;
			end
			"-": begin
				if (b == "-") cls = CLS_DEC;
				else if (b == "=") cls = CLS_MINUS_EQ;
				else if (b == ">") cls = CLS_ARROW;
			end
			"*": if (b == "=") cls = CLS_STAR_EQ;
			"/": if (b == "=") cls = CLS_SLASH_EQ;
			"%": if (b == "=") cls = CLS_PCT_EQ;
			"&": if (b == "=") cls = CLS_AMP_EQ;
			"|": if (b == "=") cls = CLS_BAR_EQ;
			":": if (b == ":") cls = CLS_SCOPE;
			default: cls = CLS_UNKNOWN;
		endcase
		return cls;
	endfunction

	// letters of the keyword "struct"
	function automatic logic [CHAR_W-1:0] kw_char(logic [2:0] idx);
		logic [CHAR_W-1:0] ch;
		case (idx)
			3'd0: ch = "s";
			3'd1: ch = "t";
			3'd2: ch = "r";
			3'd3: ch = "u";
			3'd4: ch = "c";
			3'd5: ch = "t";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* src/stt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_if: stream channels of the tokenizer
// Source byte channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stt_in_if;
	logic                      valid;
	logic                      ready;
	logic [stt_pkg::CHAR_W-1:0] in_char;
	logic                      end_of_input;

	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

interface stt_out_if;
	logic                            valid;
	logic                            ready;
	logic [stt_pkg::CHAR_W-1:0]       out_char;
	logic                            char_valid;
	logic                            last_of_token;
	logic [stt_pkg::CLASS_W-1:0]      token_class;
	logic [stt_pkg::LINE_FIELD_W-1:0] line_number;

	modport source (output valid, output out_char, output char_valid, output last_of_token,
		output token_class, output line_number, input ready);
	modport sink (input valid, input out_char, input char_valid, input last_of_token,
		input token_class, input line_number, output ready);
endinterface

/* src/stt_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_cfg: register block
// APB-style access to the first_line register; flags a write so the
// scanner can load its line counter in the same cycle.
// ----------------------------------------------------------------------------
module stt_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stt_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [stt_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [stt_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	output stt_pkg::cfg_t                      cfg
);
	import stt_pkg::*;

	logic [LINE_FIELD_W-1:0] first_line_q;
	logic                    hit;
	logic                    wr;

	// decode the register index from the word address
	assign hit   = (paddr[CFG_ADDR_W-1:2] == REG_FIRST_LINE);
	assign wr    = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// hold the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q <= FIRST_LINE_RESET;
		end else if (wr && hit) begin
			first_line_q <= pwdata[LINE_FIELD_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = CFG_DATA_W'(first_line_q);
		end
	end

	assign cfg.load       = wr && hit;
	assign cfg.load_value = pwdata[LINE_FIELD_W-1:0];
	assign cfg.first_line = first_line_q;

endmodule

/* src/stt_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_scan: input register and scanner
// Registers one source word, then runs one scanner step on it and hands
// up to two result words to the result queue.
// ----------------------------------------------------------------------------
module stt_scan #(
	parameter int LINE_BITS = stt_pkg::LINE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	stt_in_if.sink         source,
	input  stt_pkg::cfg_t  cfg,
	input  logic           room,
	output stt_pkg::push_t push
);
	import stt_pkg::*;

	// input stage
	logic              v_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eoi_s1;
	logic              adv;

	// scanner state
	mode_t             mode_q, mode_d;
	logic [CHAR_W-1:0] held_q, held_d;
	logic              hv_q, hv_d;
	logic              saw_q, saw_d;
	logic [2:0]        kw_q, kw_d;
	logic [LINE_BITS-1:0] line_q, line_d;

	// step outputs
	logic              e0, es, do_start;
	result_t           r0, rs;
	logic [31:0]       line_wide;
	logic [LINE_FIELD_W-1:0] line_out;
	logic [CHAR_W-1:0] c, esc_c;
	token_class_t      pc;

	function automatic result_t mk(logic [CHAR_W-1:0] ch, logic v, logic l,
			token_class_t cls, logic [LINE_FIELD_W-1:0] ln);
		result_t r;
		r.out_char      = ch;
		r.char_valid    = v;
		r.last_of_token = l;
		r.token_class   = cls;
		r.line_number   = ln;
		return r;
	endfunction

	assign source.ready = !v_s1 || room;
	assign adv          = v_s1 && room;

	// hold the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (source.ready) begin
			v_s1 <= source.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (source.ready && source.valid) begin
			char_s1 <= source.in_char;
			eoi_s1  <= source.end_of_input;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= '0;
			hv_q   <= 1'b0;
			saw_q  <= 1'b0;
			kw_q   <= '0;
			line_q <= LINE_BITS'(FIRST_LINE_RESET);
		end else if (cfg.load) begin
			line_q <= LINE_BITS'(cfg.load_value);
		end else if (adv) begin
			mode_q <= mode_d;
			held_q <= held_d;
			hv_q   <= hv_d;
			saw_q  <= saw_d;
			kw_q   <= kw_d;
			line_q <= line_d;
		end
	end

	assign line_wide = 32'(line_q);
	assign line_out  = line_wide[LINE_FIELD_W-1:0];
	assign c         = char_s1;
	assign pc        = pair_class(held_q, c);
	assign esc_c     = (c == CH_ESC_N) ? CH_NL : (c == CH_ESC_T) ? CH_TAB : c;

	// next state and result words for one source word
	always_comb begin
		mode_d   = mode_q;
		held_d   = held_q;
		hv_d     = hv_q;
		saw_d    = saw_q;
		kw_d     = kw_q;
		line_d   = line_q;
		e0       = 1'b0;
		r0       = '0;
		es       = 1'b0;
		rs       = '0;
		do_start = 1'b0;

		if (eoi_s1) begin
			// flush the pending token and rewind the line count
			unique case (mode_q)
				MODE_NUM: begin
					e0 = 1'b1;
					r0 = mk(held_q, 1'b1, 1'b1, saw_q ? CLS_FLOAT : CLS_INT, line_out);
				end
				MODE_IDENT: begin
					e0 = 1'b1;
					r0 = mk(held_q, 1'b1, 1'b1, (kw_q == KW_LEN) ? CLS_STRUCT : CLS_IDENT,
						line_out);
				end
				MODE_OPER: begin
					e0 = 1'b1;
					r0 = mk(held_q, 1'b1, 1'b1, single_class(held_q), line_out);
				end
				MODE_STR, MODE_ESC: begin
					e0 = 1'b1;
					r0 = hv_q ? mk(held_q, 1'b1, 1'b1, CLS_STRING, line_out)
						: mk('0, 1'b0, 1'b1, CLS_STRING, line_out);
				end
				default: begin
				end
			endcase
			mode_d = MODE_IDLE;
			hv_d   = 1'b0;
			line_d = LINE_BITS'(cfg.first_line);
		end else begin
			unique case (mode_q)
				MODE_NUM: begin
					e0 = 1'b1;
					if (is_digit(c) || (c == CH_DOT)) begin
						r0     = mk(held_q, 1'b1, 1'b0, CLS_UNKNOWN, line_out);
						held_d = c;
						if (c == CH_DOT) saw_d = 1'b1;
					end else begin
						r0       = mk(held_q, 1'b1, 1'b1, saw_q ? CLS_FLOAT : CLS_INT,
							line_out);
						mode_d   = MODE_IDLE;
						hv_d     = 1'b0;
						do_start = 1'b1;
					end
				end
				MODE_IDENT: begin
					e0 = 1'b1;
					if (is_alpha(c) || is_digit(c)) begin
						r0     = mk(held_q, 1'b1, 1'b0, CLS_UNKNOWN, line_out);
						held_d = c;
						kw_d   = ((kw_q < KW_LEN) && (c == kw_char(kw_q))) ? kw_q + 3'd1
							: KW_DEAD;
					end else begin
						r0 = mk(held_q, 1'b1, 1'b1,
							(kw_q == KW_LEN) ? CLS_STRUCT : CLS_IDENT, line_out);
						mode_d   = MODE_IDLE;
						hv_d     = 1'b0;
						do_start = 1'b1;
					end
				end
				MODE_OPER: begin
					e0     = 1'b1;
					mode_d = MODE_IDLE;
					hv_d   = 1'b0;
					if (pc != CLS_UNKNOWN) begin
						// two-character operator closes here
						r0 = mk(held_q, 1'b1, 1'b0, CLS_UNKNOWN, line_out);
						es = 1'b1;
						rs = mk(c, 1'b1, 1'b1, pc, line_out);
					end else begin
						r0       = mk(held_q, 1'b1, 1'b1, single_class(held_q), line_out);
						do_start = 1'b1;
					end
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						e0 = 1'b1;
						r0 = hv_q ? mk(held_q, 1'b1, 1'b1, CLS_STRING, line_out)
							: mk('0, 1'b0, 1'b1, CLS_STRING, line_out);
						mode_d = MODE_IDLE;
						hv_d   = 1'b0;
					end else if (c == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						e0     = hv_q;
						r0     = mk(held_q, 1'b1, 1'b0, CLS_UNKNOWN, line_out);
						held_d = c;
						hv_d   = 1'b1;
					end
				end
				MODE_ESC: begin
					e0     = hv_q;
					r0     = mk(held_q, 1'b1, 1'b0, CLS_UNKNOWN, line_out);
					held_d = esc_c;
					hv_d   = 1'b1;
					mode_d = MODE_STR;
				end
				default: begin
					mode_d   = MODE_IDLE;
					do_start = 1'b1;
				end
			endcase
		end

		// open a new token with the current byte
		if (do_start) begin
			if ((c == CH_SPACE) || (c == CH_TAB)) begin
			end else if (c == CH_NL) begin
				line_d = line_q + LINE_BITS'(1);
			end else if (is_digit(c)) begin
				mode_d = MODE_NUM;
				held_d = c;
				hv_d   = 1'b1;
				saw_d  = 1'b0;
			end else if (c == CH_QUOTE) begin
				mode_d = MODE_STR;
				hv_d   = 1'b0;
			end else if (needs_lookahead(c)) begin
				mode_d = MODE_OPER;
				held_d = c;
				hv_d   = 1'b1;
			end else if (is_alpha(c)) begin
				mode_d = MODE_IDENT;
				held_d = c;
				hv_d   = 1'b1;
				kw_d   = (c == kw_char(3'd0)) ? 3'd1 : KW_DEAD;
			end else begin
				es = 1'b1;
				rs = mk(c, 1'b1, 1'b1, single_class(c), line_out);
			end
		end
	end

	// pack results into the first free slots
	assign push.en0   = adv && (e0 || es);
	assign push.en1   = adv && e0 && es;
	assign push.item0 = e0 ? r0 : rs;
	assign push.item1 = rs;

endmodule

/* src/stt_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_outq: result queue
// Small register queue that takes up to two result words a cycle while room is
// high and presents one a cycle on the result channel while it is ready.
// ----------------------------------------------------------------------------
module stt_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_pkg::push_t push,
	output logic           room,
	stt_out_if.source      result
);
	import stt_pkg::*;

	result_t               mem [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wp_q;
	logic [OUTQ_PTR_W-1:0] rp_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic                  pop;
	result_t               head;

	assign pop  = result.valid && result.ready;
	assign room = (cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUTQ_PTR_W'(push.en0) + OUTQ_PTR_W'(push.en1);
			rp_q  <= rp_q + OUTQ_PTR_W'(pop);
			cnt_q <= cnt_q + OUTQ_CNT_W'(push.en0) + OUTQ_CNT_W'(push.en1)
				- OUTQ_CNT_W'(pop);
		end
	end

	// store incoming words
	always_ff @(posedge clk) begin
		if (push.en0) begin
			mem[wp_q] <= push.item0;
		end
		if (push.en1) begin
			mem[wp_q + OUTQ_PTR_W'(1)] <= push.item1;
		end
	end

	assign head                 = mem[rp_q];
	assign result.valid         = (cnt_q != '0);
	assign result.out_char      = head.out_char;
	assign result.char_valid    = head.char_valid;
	assign result.last_of_token = head.last_of_token;
	assign result.token_class   = head.token_class;
	assign result.line_number   = head.line_number;

endmodule

/* src/source_text_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_core: streaming source text tokenizer
// Takes one source byte per word and emits token characters, the last one
// of each token tagged with its class and line number.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake        payload
//  source    in    valid / ready    in_char, end_of_input
//  result    out   valid / ready    out_char, char_valid, last_of_token,
//                                   token_class, line_number
//  apb       in    psel / penable   first_line at byte address 0
//
// One source word per cycle while the queue has room; each yields zero, one or two
// result words, through the input register and a 4-word queue.
// The queue drains at most one word a cycle, so a run of two-word steps slows intake.
// Reset clears the scanner to idle, the queue to empty, first_line to 1.
// A stalled result channel fills the queue and then holds source.ready low.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core #(
	parameter int LINE_BITS = stt_pkg::LINE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	stt_in_if.sink                         source,
	stt_out_if.source                      result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [stt_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [stt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [stt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import stt_pkg::*;

	cfg_t  cfg;
	push_t push;
	logic  room;

	stt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	stt_scan #(
		.LINE_BITS (LINE_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.source (source),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	stt_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

/* dv/source_text_tokenizer_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_core_test: self-checking bench of the tokenizer core
// Feeds source text one byte per word, with random idle gaps on the source
// side and random stalls on the result side. A scanner model inside the
// bench predicts each token character word, or a directed row supplies it,
// and each received word is compared field by field. The first_line register
// is rewritten between phases, including both ends of its range, and read back.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core_test;
	import stt_pkg::*;

	localparam int HOLD_CYCLES = 60;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_WORDS = 36;

	typedef struct packed {
		logic                    eoi;
		logic [CHAR_W-1:0]       ch;
	} src_word_t;

	typedef struct packed {
		logic                    eoi;
		logic [CHAR_W-1:0]       ch;
		logic                    typed;
		result_t                 want;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	stt_in_if src_ch ();
	stt_out_if res_ch ();

	source_text_tokenizer_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.source  (src_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// scanner model state
	mode_t                    scan_st;
	logic [CHAR_W-1:0]        held;
	logic                     held_ok;
	logic                     dot_seen;
	logic [2:0]               kw_pos;
	logic [LINE_BITS_DEF-1:0] line_cnt;
	logic [LINE_FIELD_W-1:0]  first_line_reg;

	result_t   expected_tokens [$];
	result_t   word_tokens [$];
	src_word_t script [$];
	row_t      plan [$];

	int      faults;
	int      quiet;
	logic    cur_typed;
	result_t cur_want;
	logic    hold_off_req;
	logic    calm;

	string kw_text     = "struct";
	string op_leads    = "+-*/%&|:";
	string op_seconds  = "+-=>:";
	string lone_puncts = "^{}()[].;,";

	always #1 clk = ~clk;

	function automatic logic digit_ch(logic [CHAR_W-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic letter_ch(logic [CHAR_W-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic op_lead(logic [CHAR_W-1:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
			c == "&" || c == "|" || c == ":";
	endfunction

	function automatic token_class_t lone_class(logic [CHAR_W-1:0] c);
		case (c)
			"+": return CLS_PLUS;
			"-": return CLS_MINUS;
			"*": return CLS_STAR;
			"/": return CLS_SLASH;
			"%": return CLS_PCT;
			"&": return CLS_AMP;
			"|": return CLS_BAR;
			"^": return CLS_CARET;
			":": return CLS_COLON;
			"{": return CLS_LBRACE;
			"}": return CLS_RBRACE;
			"(": return CLS_LPAREN;
			")": return CLS_RPAREN;
			"[": return CLS_LBRACK;
			"]": return CLS_RBRACK;
			".": return CLS_DOT;
			";": return CLS_SEMI;
			",": return CLS_COMMA;
			default: return CLS_UNKNOWN;
		endcase
	endfunction

	// two-character operator, unknown when the pair forms none
	function automatic token_class_t twin_class(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
		case (a)
			"+": return b == "+" ? CLS_INC : b == "=" ? CLS_PLUS_EQ : CLS_UNKNOWN;
			"-": return b == "-" ? CLS_DEC : b == "=" ? CLS_MINUS_EQ :
				b == ">" ? CLS_ARROW : CLS_UNKNOWN;
			"*": return b == "=" ? CLS_STAR_EQ : CLS_UNKNOWN;
			"/": return b == "=" ? CLS_SLASH_EQ : CLS_UNKNOWN;
			"%": return b == "=" ? CLS_PCT_EQ : CLS_UNKNOWN;
			"&": return b == "=" ? CLS_AMP_EQ : CLS_UNKNOWN;
			"|": return b == "=" ? CLS_BAR_EQ : CLS_UNKNOWN;
			":": return b == ":" ? CLS_SCOPE : CLS_UNKNOWN;
			default: return CLS_UNKNOWN;
		endcase
	endfunction

	function automatic result_t make_token(logic [CHAR_W-1:0] c, logic cv, logic last,
		token_class_t cls, logic [LINE_FIELD_W-1:0] line);
		result_t r;
		r.out_char      = c;
		r.char_valid    = cv;
		r.last_of_token = last;
		r.token_class   = cls;
		r.line_number   = line;
		return r;
	endfunction

	function automatic void push_token(logic [CHAR_W-1:0] c, logic cv, logic last,
		token_class_t cls);
		word_tokens.insert(word_tokens.size(),
			make_token(c, cv, last, cls, LINE_FIELD_W'(line_cnt)));
	endfunction

	function automatic void kw_step(logic [CHAR_W-1:0] c);
		if (kw_pos < KW_LEN && c == kw_text[kw_pos]) begin
			kw_pos = kw_pos + 3'd1;
		end else begin
			kw_pos = KW_DEAD;
		end
	endfunction

	function automatic void string_step(logic [CHAR_W-1:0] c);
		if (held_ok) begin
			push_token(held, 1'b1, 1'b0, CLS_UNKNOWN);
		end
		held    = c;
		held_ok = 1'b1;
	endfunction

	function automatic void drop_token();
		scan_st = MODE_IDLE;
		held_ok = 1'b0;
	endfunction

	function automatic void begin_token(logic [CHAR_W-1:0] c);
		if (c == CH_SPACE || c == CH_TAB) begin
			return;
		end
		if (c == CH_NL) begin
			line_cnt = line_cnt + 1'b1;
		end else if (digit_ch(c)) begin
			scan_st  = MODE_NUM;
			held     = c;
			held_ok  = 1'b1;
			dot_seen = 1'b0;
		end else if (c == CH_QUOTE) begin
			scan_st = MODE_STR;
			held_ok = 1'b0;
		end else if (op_lead(c)) begin
			scan_st = MODE_OPER;
			held    = c;
			held_ok = 1'b1;
		end else if (letter_ch(c)) begin
			scan_st = MODE_IDENT;
			held    = c;
			held_ok = 1'b1;
			kw_pos  = '0;
			kw_step(c);
		end else begin
			push_token(c, 1'b1, 1'b1, lone_class(c));
		end
	endfunction

	// advance the scanner by one source word, leaving its tokens in word_tokens
	function automatic void tokenize_word(logic eoi, logic [CHAR_W-1:0] c);
		logic restart;
		token_class_t pc;
		word_tokens.delete();
		if (eoi) begin
			case (scan_st)
				MODE_NUM: push_token(held, 1'b1, 1'b1, dot_seen ? CLS_FLOAT : CLS_INT);
				MODE_IDENT: push_token(held, 1'b1, 1'b1,
					kw_pos == KW_LEN ? CLS_STRUCT : CLS_IDENT);
				MODE_OPER: push_token(held, 1'b1, 1'b1, lone_class(held));
				MODE_STR, MODE_ESC: begin
					if (held_ok) push_token(held, 1'b1, 1'b1, CLS_STRING);
					else push_token('0, 1'b0, 1'b1, CLS_STRING);
				end
				default: ;
			endcase
			drop_token();
			line_cnt = first_line_reg;
			return;
		end
		restart = 1'b1;
		case (scan_st)
			MODE_NUM: begin
				if (digit_ch(c) || c == CH_DOT) begin
					push_token(held, 1'b1, 1'b0, CLS_UNKNOWN);
					held = c;
					if (c == CH_DOT) dot_seen = 1'b1;
					restart = 1'b0;
				end else begin
					push_token(held, 1'b1, 1'b1, dot_seen ? CLS_FLOAT : CLS_INT);
					drop_token();
				end
			end
			MODE_IDENT: begin
				if (letter_ch(c) || digit_ch(c)) begin
					push_token(held, 1'b1, 1'b0, CLS_UNKNOWN);
					held = c;
					kw_step(c);
					restart = 1'b0;
				end else begin
					push_token(held, 1'b1, 1'b1, kw_pos == KW_LEN ? CLS_STRUCT : CLS_IDENT);
					drop_token();
				end
			end
			MODE_OPER: begin
				pc = twin_class(held, c);
				if (pc != CLS_UNKNOWN) begin
					push_token(held, 1'b1, 1'b0, CLS_UNKNOWN);
					push_token(c, 1'b1, 1'b1, pc);
					restart = 1'b0;
				end else begin
					push_token(held, 1'b1, 1'b1, lone_class(held));
				end
				drop_token();
			end
			MODE_STR: begin
				restart = 1'b0;
				if (c == CH_QUOTE) begin
					if (held_ok) push_token(held, 1'b1, 1'b1, CLS_STRING);
					else push_token('0, 1'b0, 1'b1, CLS_STRING);
					drop_token();
				end else if (c == CH_BSLASH) begin
					scan_st = MODE_ESC;
				end else begin
					string_step(c);
				end
			end
			MODE_ESC: begin
				restart = 1'b0;
				string_step(c == CH_ESC_N ? CH_NL : c == CH_ESC_T ? CH_TAB : c);
				scan_st = MODE_STR;
			end
			default: scan_st = MODE_IDLE;
		endcase
		if (restart) begin_token(c);
	endfunction

	function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			faults++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_token(result_t got);
		result_t want;
		if (expected_tokens.size() == 0) begin
			faults++;
			$display("%0t ns: result word %0h with none expected", $time, got);
			return;
		end
		want = expected_tokens.pop_front();
		note_field("out_char", 32'(want.out_char), 32'(got.out_char));
		note_field("char_valid", 32'(want.char_valid), 32'(got.char_valid));
		note_field("last_of_token", 32'(want.last_of_token), 32'(got.last_of_token));
		note_field("token_class", 32'(want.token_class), 32'(got.token_class));
		note_field("line_number", 32'(want.line_number), 32'(got.line_number));
	endfunction

	// predict on each accepted source word, check each accepted result word
	always @(posedge clk) begin : monitor
		result_t got;
		if (arst_n) begin
			if (src_ch.valid && src_ch.ready) begin
				tokenize_word(src_ch.end_of_input, src_ch.in_char);
				if (cur_typed) begin
					expected_tokens.insert(expected_tokens.size(), cur_want);
				end else begin
					foreach (word_tokens[i])
						expected_tokens.insert(expected_tokens.size(), word_tokens[i]);
				end
			end
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.out_char, res_ch.char_valid, res_ch.last_of_token,
					res_ch.token_class, res_ch.line_number};
				check_token(got);
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(psel && penable)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("source_text_tokenizer_core verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// offer one word; entered and left at a falling edge
	task automatic offer_word(input logic eoi, input logic [CHAR_W-1:0] ch);
		if (!calm && $urandom_range(0, 4) == 0) begin
			src_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		src_ch.valid        <= 1'b1;
		src_ch.in_char      <= ch;
		src_ch.end_of_input <= eoi;
		do @(posedge clk); while (!src_ch.ready);
		@(negedge clk);
	endtask

	// write first_line, then read it back
	task automatic cfg_write(input logic [LINE_FIELD_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_FIRST_LINE, 2'b00};
		pwdata  <= CFG_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		first_line_reg = value;
		line_cnt       = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		note_field("first_line readback", CFG_DATA_W'(value), prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every expected word, then let the pipeline go quiet
	task automatic settle();
		do @(negedge clk); while (expected_tokens.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	function automatic void put_char(logic [CHAR_W-1:0] ch);
		script.insert(script.size(), {1'b0, ch});
	endfunction

	function automatic logic [CHAR_W-1:0] any_letter();
		return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) :
			8'("A" + $urandom_range(0, 25));
	endfunction

	// append one random piece of source text, mostly well-formed tokens
	function automatic void add_fragment();
		int kind;
		int n;
		int i;
		string pick;
		kind = $urandom_range(0, 99);
		if (kind < 18) begin
			put_char(8'("0" + $urandom_range(0, 9)));
			n = $urandom_range(0, 5);
			repeat (n) put_char($urandom_range(0, 4) == 0 ? CH_DOT :
				8'("0" + $urandom_range(0, 9)));
		end else if (kind < 38) begin
			case ($urandom_range(0, 6))
				0: pick = "struct";
				1: pick = "structs";
				2: pick = "stru";
				3: pick = "Struct";
				default: pick = "";
			endcase
			if (pick.len() == 0) begin
				put_char(any_letter());
				n = $urandom_range(0, 6);
				repeat (n) put_char($urandom_range(0, 3) == 0 ?
					8'("0" + $urandom_range(0, 9)) : any_letter());
			end else begin
				for (i = 0; i < pick.len(); i++) put_char(pick[i]);
			end
		end else if (kind < 58) begin
			put_char(CH_QUOTE);
			n = $urandom_range(0, 5);
			repeat (n) begin
				case ($urandom_range(0, 7))
					0: begin
						put_char(CH_BSLASH);
						case ($urandom_range(0, 4))
							0: put_char(CH_ESC_N);
							1: put_char(CH_ESC_T);
							2: put_char(CH_QUOTE);
							3: put_char(CH_BSLASH);
							default: put_char(8'($urandom_range(8'h20, 8'h7E)));
						endcase
					end
					1: put_char(CH_NL);
					default: put_char(8'($urandom_range(8'h20, 8'h7E)));
				endcase
			end
			// mostly closed; otherwise end the text inside the string
			if ($urandom_range(0, 9) != 0) begin
				put_char(CH_QUOTE);
			end else begin
				if ($urandom_range(0, 1)) put_char(CH_BSLASH);
				script.insert(script.size(), {1'b1, 8'($urandom_range(0, 255))});
			end
		end else if (kind < 78) begin
			if ($urandom_range(0, 3) == 0) begin
				put_char(lone_puncts[$urandom_range(0, lone_puncts.len() - 1)]);
			end else begin
				put_char(op_leads[$urandom_range(0, op_leads.len() - 1)]);
				case ($urandom_range(0, 2))
					0: put_char("=");
					1: put_char(op_seconds[$urandom_range(0, op_seconds.len() - 1)]);
					default: ;
				endcase
			end
		end else if (kind < 90) begin
			case ($urandom_range(0, 2))
				0: put_char(CH_SPACE);
				1: put_char(CH_TAB);
				default: put_char(CH_NL);
			endcase
		end else if (kind < 96) begin
			put_char(8'($urandom_range(0, 255)));
		end else begin
			script.insert(script.size(), {1'b1, 8'($urandom_range(0, 255))});
		end
	endfunction

	// random text of about n words, closed by end of input
	task automatic run_phase(input int n);
		script.delete();
		while (script.size() < n) add_fragment();
		script.insert(script.size(), {1'b1, 8'($urandom_range(0, 255))});
		foreach (script[i]) offer_word(script[i].eoi, script[i].ch);
		src_ch.valid <= 1'b0;
	endtask

	function automatic row_t plain(logic eoi, logic [CHAR_W-1:0] ch);
		row_t r;
		r       = '0;
		r.eoi   = eoi;
		r.ch    = ch;
		return r;
	endfunction

	function automatic row_t checked(logic eoi, logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] c,
		logic cv, token_class_t cls, logic [LINE_FIELD_W-1:0] line);
		row_t r;
		r       = plain(eoi, ch);
		r.typed = 1'b1;
		r.want  = make_token(c, cv, 1'b1, cls, line);
		return r;
	endfunction

	initial begin : stimulus
		clk                 = 1'b0;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		src_ch.valid        = 1'b0;
		src_ch.in_char      = '0;
		src_ch.end_of_input = 1'b0;
		faults              = 0;
		cur_typed           = 1'b0;
		cur_want            = '0;
		hold_off_req        = 1'b0;
		calm                = 1'b0;
		scan_st             = MODE_IDLE;
		held                = '0;
		held_ok             = 1'b0;
		dot_seen            = 1'b0;
		kw_pos              = '0;
		first_line_reg      = FIRST_LINE_RESET;
		line_cnt            = FIRST_LINE_RESET;

		// directed text; lines count from the reset value of first_line
		plan.insert(plan.size(), plain(1'b1, 8'hA5));
		plan.insert(plan.size(), checked(1'b0, "=", "=", 1'b1, CLS_UNKNOWN, 20'd1));
		plan.insert(plan.size(), checked(1'b0, 8'hFF, 8'hFF, 1'b1, CLS_UNKNOWN, 20'd1));
		plan.insert(plan.size(), checked(1'b0, 8'h00, 8'h00, 1'b1, CLS_UNKNOWN, 20'd1));
		plan.insert(plan.size(), plain(1'b0, "1"));
		plan.insert(plan.size(), plain(1'b0, "."));
		plan.insert(plan.size(), plain(1'b0, "5"));
		plan.insert(plan.size(), checked(1'b0, CH_SPACE, "5", 1'b1, CLS_FLOAT, 20'd1));
		plan.insert(plan.size(), plain(1'b0, "s"));
		plan.insert(plan.size(), plain(1'b0, "t"));
		plan.insert(plan.size(), plain(1'b0, "r"));
		plan.insert(plan.size(), plain(1'b0, "u"));
		plan.insert(plan.size(), plain(1'b0, "c"));
		plan.insert(plan.size(), plain(1'b0, "t"));
		plan.insert(plan.size(), checked(1'b0, CH_NL, "t", 1'b1, CLS_STRUCT, 20'd1));
		// escaped and raw newline inside a string
		plan.insert(plan.size(), plain(1'b0, CH_QUOTE));
		plan.insert(plan.size(), plain(1'b0, CH_BSLASH));
		plan.insert(plan.size(), plain(1'b0, CH_ESC_N));
		plan.insert(plan.size(), plain(1'b0, CH_NL));
		plan.insert(plan.size(), plain(1'b0, CH_QUOTE));
		// empty string
		plan.insert(plan.size(), plain(1'b0, CH_QUOTE));
		plan.insert(plan.size(), checked(1'b0, CH_QUOTE, 8'h00, 1'b0, CLS_STRING, 20'd2));
		plan.insert(plan.size(), plain(1'b0, "-"));
		plan.insert(plan.size(), plain(1'b0, ">"));
		// colon closed by a caret: two tokens from one word
		plan.insert(plan.size(), plain(1'b0, ":"));
		plan.insert(plan.size(), plain(1'b0, "^"));
		// string left open with a dangling backslash
		plan.insert(plan.size(), plain(1'b0, CH_QUOTE));
		plan.insert(plan.size(), plain(1'b0, CH_BSLASH));
		plan.insert(plan.size(), checked(1'b1, 8'h00, 8'h00, 1'b0, CLS_STRING, 20'd2));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			cur_typed = plan[k].typed;
			cur_want  = plan[k].want;
			offer_word(plan[k].eoi, plan[k].ch);
		end
		cur_typed = 1'b0;
		run_phase(PHASE_WORDS);
		settle();

		// lowest first line, with the result side held off to back up the queue
		cfg_write('0);
		calm         = 1'b1;
		hold_off_req = 1'b1;
		run_phase(PHASE_WORDS);
		calm = 1'b0;
		settle();

		// highest first line: a newline wraps the count
		cfg_write('1);
		run_phase(PHASE_WORDS);
		settle();

		// random first line, no idling on either side
		cfg_write(LINE_FIELD_W'($urandom_range(2, 20'hFFFFE)));
		calm = 1'b1;
		run_phase(PHASE_WORDS);

		while (expected_tokens.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (faults == 0) begin
			$display("source_text_tokenizer_core verification clean");
		end else begin
			$display("source_text_tokenizer_core verification failed");
		end
		$finish;
	end

endmodule

/* source_text_tokenizer_core.f */
src/stt_pkg.sv
src/stt_if.sv
src/stt_cfg.sv
src/stt_scan.sv
src/stt_outq.sv
src/source_text_tokenizer_core.sv
dv/source_text_tokenizer_core_test.sv
